// ===== rtl/bwf_pkg.sv =====
// Shared types and constants for the box window filter.
`default_nettype none

package bwf_pkg;

    localparam int MAX_WINDOW = 15;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 16;

    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int DIM_W      = 11;
    localparam int RAD_W      = 3;
    localparam int WIN_W      = RAD_W + 1;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int RS_W       = 20;
    localparam int CS_W       = 24;
    localparam int VAL_W      = 16;
    localparam int AREA_W     = 2 * WIN_W;
    localparam int DVD_W      = CS_W + 1;
    localparam int STEP_W     = $clog2(DVD_W);
    localparam int MEM_AW     = $clog2(MAX_WINDOW * MAX_WIDTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = QPTR_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [RAD_W-1:0] RADIUS_LIM = RAD_W'((MAX_WINDOW - 1) / 2);

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE    = 3'd5;

    localparam logic MODE_MEAN  = 1'b0;
    localparam logic MODE_CLAMP = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0]  cx;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] rd_slot;
        logic              first_row;
        logic              use_old;
        logic [RS_W-1:0]   hs;
        logic              emit;
        logic              full;
        logic [COL_W-1:0]  center_x;
        logic [ROW_W-1:0]  center_y;
        logic [AREA_W-1:0] area;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CALC,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/bwf_front.sv =====
// Front end: raster position, horizontal running sum and command build.
`default_nettype none

module bwf_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [bwf_pkg::PIXEL_BITS-1:0] pixel,
    input  wire logic                        q_full,
    input  wire logic [bwf_pkg::RAD_W-1:0]   radius_x,
    input  wire logic [bwf_pkg::RAD_W-1:0]   radius_y,
    input  wire logic [bwf_pkg::DIM_W-1:0]   image_width,
    input  wire logic [bwf_pkg::DIM_W-1:0]   image_height,
    output logic                             push,
    output bwf_pkg::cmd_t                    cmd
);

    logic [bwf_pkg::COL_W-1:0]      col_reg, col_next;
    logic [bwf_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [bwf_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [bwf_pkg::RS_W-1:0]       row_sum_reg;
    logic [bwf_pkg::PIXEL_BITS-1:0] line_reg [bwf_pkg::MAX_WINDOW];

    logic [bwf_pkg::RAD_W-1:0]  rx, ry;
    logic [bwf_pkg::WIN_W-1:0]  wx, wy;
    logic [bwf_pkg::DIM_W-1:0]  w_eff, h_eff, col_inc, row_inc;
    logic                       row_start;
    logic [bwf_pkg::PIXEL_BITS-1:0] old_px;
    logic [bwf_pkg::RS_W-1:0]   hs;
    logic [bwf_pkg::SLOT_W:0]   rd_tmp;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        rx = (radius_x > bwf_pkg::RADIUS_LIM) ? bwf_pkg::RADIUS_LIM : radius_x;
        ry = (radius_y > bwf_pkg::RADIUS_LIM) ? bwf_pkg::RADIUS_LIM : radius_y;
        wx = {rx, 1'b1};
        wy = {ry, 1'b1};

        if (image_width == '0)
            w_eff = bwf_pkg::DIM_W'(1);
        else if (image_width > bwf_pkg::DIM_W'(bwf_pkg::MAX_WIDTH))
            w_eff = bwf_pkg::DIM_W'(bwf_pkg::MAX_WIDTH);
        else
            w_eff = image_width;

        if (image_height == '0)
            h_eff = bwf_pkg::DIM_W'(1);
        else if (image_height > bwf_pkg::DIM_W'(bwf_pkg::MAX_HEIGHT))
            h_eff = bwf_pkg::DIM_W'(bwf_pkg::MAX_HEIGHT);
        else
            h_eff = image_height;

        // drop the previous row's pixels at the row start
        row_start = (col_reg == '0);
        old_px    = row_start ? '0 : line_reg[{rx, 1'b0}];
        hs        = (row_start ? '0 : row_sum_reg) + bwf_pkg::RS_W'(pixel)
                    - bwf_pkg::RS_W'(old_px);

        rd_tmp = {1'b0, slot_reg} + (bwf_pkg::SLOT_W + 1)'(bwf_pkg::MAX_WINDOW)
                 - (bwf_pkg::SLOT_W + 1)'(wy);
        if (rd_tmp >= (bwf_pkg::SLOT_W + 1)'(bwf_pkg::MAX_WINDOW))
            rd_tmp = rd_tmp - (bwf_pkg::SLOT_W + 1)'(bwf_pkg::MAX_WINDOW);

        cmd.cx        = col_reg;
        cmd.slot      = slot_reg;
        cmd.rd_slot   = rd_tmp[bwf_pkg::SLOT_W-1:0];
        cmd.first_row = (row_reg == '0);
        cmd.use_old   = (row_reg >= bwf_pkg::ROW_W'(wy));
        cmd.hs        = hs;
        cmd.emit      = (col_reg >= bwf_pkg::COL_W'(rx)) && (row_reg >= bwf_pkg::ROW_W'(ry));
        cmd.full      = (col_reg >= bwf_pkg::COL_W'({rx, 1'b0}))
                        && (row_reg >= bwf_pkg::ROW_W'({ry, 1'b0}));
        cmd.center_x  = col_reg - bwf_pkg::COL_W'(rx);
        cmd.center_y  = row_reg - bwf_pkg::ROW_W'(ry);
        cmd.area      = bwf_pkg::AREA_W'(wx) * bwf_pkg::AREA_W'(wy);

        // advance the raster position
        col_inc   = {1'b0, col_reg} + bwf_pkg::DIM_W'(1);
        row_inc   = {1'b0, row_reg} + bwf_pkg::DIM_W'(1);
        col_next  = col_inc[bwf_pkg::COL_W-1:0];
        row_next  = row_reg;
        slot_next = slot_reg;
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            if (row_inc >= h_eff)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = row_inc[bwf_pkg::ROW_W-1:0];
                slot_next = (slot_reg == bwf_pkg::SLOT_W'(bwf_pkg::MAX_WINDOW - 1))
                            ? '0 : slot_reg + bwf_pkg::SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            slot_reg    <= '0;
            row_sum_reg <= '0;
            for (int i = 0; i < bwf_pkg::MAX_WINDOW; i++)
                line_reg[i] <= '0;
        end
        else if (push)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            slot_reg    <= slot_next;
            row_sum_reg <= hs;
            line_reg[0] <= pixel;
            for (int i = 1; i < bwf_pkg::MAX_WINDOW; i++)
                line_reg[i] <= row_start ? '0 : line_reg[i-1];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bwf_queue.sv =====
// Short command queue between front end and back end.
`default_nettype none

module bwf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bwf_pkg::cmd_t push_data,
    input  wire logic          pop,
    output bwf_pkg::cmd_t      pop_data,
    output logic               full,
    output logic               empty
);

    bwf_pkg::cmd_t               entry_reg [bwf_pkg::QUEUE_DEPTH];
    logic [bwf_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [bwf_pkg::QCNT_W-1:0]  count_reg;

    assign full     = (count_reg == bwf_pkg::QCNT_W'(bwf_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + bwf_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + bwf_pkg::QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + bwf_pkg::QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - bwf_pkg::QCNT_W'(1);
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + bwf_pkg::QCNT_W'(1)))
        else $error("queue count lost a push");

endmodule

`default_nettype wire

// ===== rtl/bwf_back.sv =====
// Back end: line and column sum memories, mean divider or clamp, output register.
`default_nettype none

module bwf_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    input  wire bwf_pkg::cmd_t                q_data,
    output logic                              pop,
    input  wire logic                         filter_mode,
    input  wire logic [bwf_pkg::VAL_W-1:0]    max_value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [bwf_pkg::COL_W-1:0]         center_x,
    output logic [bwf_pkg::ROW_W-1:0]         center_y,
    output logic                              window_full,
    output logic [bwf_pkg::VAL_W-1:0]         value
);

    logic [bwf_pkg::RS_W-1:0] row_mem [bwf_pkg::MAX_WINDOW * bwf_pkg::MAX_WIDTH];
    logic [bwf_pkg::CS_W-1:0] col_mem [bwf_pkg::MAX_WIDTH];

    bwf_pkg::back_state_t        state_reg, state_next;
    bwf_pkg::cmd_t               cmd_reg;
    logic [bwf_pkg::RS_W-1:0]    row_rd_reg;
    logic [bwf_pkg::CS_W-1:0]    col_rd_reg;
    logic [bwf_pkg::DVD_W-1:0]   dvd_reg, dvd_next;
    logic [bwf_pkg::AREA_W-1:0]  rem_reg, rem_next;
    logic [bwf_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [bwf_pkg::VAL_W-1:0]   val_reg, val_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        load_out;

    logic [bwf_pkg::MEM_AW-1:0]  rd_addr, wr_addr;
    logic [bwf_pkg::RS_W-1:0]    old_sum;
    logic [bwf_pkg::CS_W-1:0]    vs;
    logic                        mem_we;
    logic [bwf_pkg::AREA_W:0]    trial;
    logic                        ge;

    assign pop       = (state_reg == bwf_pkg::BK_IDLE) && !q_empty;
    assign mem_we    = (state_reg == bwf_pkg::BK_CALC);
    assign rd_addr   = bwf_pkg::MEM_AW'({q_data.rd_slot, q_data.cx});
    assign wr_addr   = bwf_pkg::MEM_AW'({cmd_reg.slot, cmd_reg.cx});
    assign out_valid = out_valid_reg;

    always_comb
    begin
        old_sum = cmd_reg.use_old ? row_rd_reg : '0;
        vs      = cmd_reg.first_row ? bwf_pkg::CS_W'(cmd_reg.hs)
                  : col_rd_reg + bwf_pkg::CS_W'(cmd_reg.hs) - bwf_pkg::CS_W'(old_sum);
        trial   = {rem_reg, dvd_reg[bwf_pkg::DVD_W-1]};
        ge      = (trial >= {1'b0, cmd_reg.area});
    end

    always_comb
    begin
        state_next     = state_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        val_next       = val_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            bwf_pkg::BK_IDLE:
            begin
                if (!q_empty)
                    state_next = bwf_pkg::BK_CALC;
            end
            bwf_pkg::BK_CALC:
            begin
                dvd_next  = bwf_pkg::DVD_W'(vs)
                            + bwf_pkg::DVD_W'(cmd_reg.area >> 1);
                rem_next  = '0;
                step_next = '0;
                if (!cmd_reg.emit)
                    state_next = bwf_pkg::BK_IDLE;
                else if (!cmd_reg.full)
                begin
                    val_next   = '0;
                    state_next = bwf_pkg::BK_DONE;
                end
                else if (filter_mode == bwf_pkg::MODE_CLAMP)
                begin
                    val_next   = (vs < bwf_pkg::CS_W'(max_value))
                                 ? vs[bwf_pkg::VAL_W-1:0] : max_value;
                    state_next = bwf_pkg::BK_DONE;
                end
                else
                    state_next = bwf_pkg::BK_DIV;
            end
            bwf_pkg::BK_DIV:
            begin
                // one restoring step per cycle, quotient shifts in at the bottom
                rem_next  = ge ? bwf_pkg::AREA_W'(trial - {1'b0, cmd_reg.area})
                               : trial[bwf_pkg::AREA_W-1:0];
                dvd_next  = {dvd_reg[bwf_pkg::DVD_W-2:0], ge};
                step_next = step_reg + bwf_pkg::STEP_W'(1);
                if (step_reg == bwf_pkg::STEP_W'(bwf_pkg::DVD_W - 1))
                begin
                    val_next   = dvd_next[bwf_pkg::VAL_W-1:0];
                    state_next = bwf_pkg::BK_DONE;
                end
            end
            bwf_pkg::BK_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = bwf_pkg::BK_IDLE;
                end
            end
            default:
                state_next = bwf_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            row_rd_reg <= row_mem[rd_addr];
            col_rd_reg <= col_mem[q_data.cx];
            cmd_reg    <= q_data;
        end
        if (mem_we)
        begin
            row_mem[wr_addr]    <= cmd_reg.hs;
            col_mem[cmd_reg.cx] <= vs;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        val_reg  <= val_next;
        if (load_out)
        begin
            center_x    <= cmd_reg.center_x;
            center_y    <= cmd_reg.center_y;
            window_full <= cmd_reg.full;
            value       <= val_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bwf_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/box_window_filter_top.sv =====
// Top level of the streaming box window filter.
//
// Usage: pixels enter in raster order on the input channel (in_valid,
// in_stall, pixel); a transaction moves one pixel. Each pixel that
// completes a window centre yields one output transaction (out_valid,
// out_stall, center_x, center_y, window_full, value); pixels in the first
// radius_y rows and first radius_x columns of a frame yield none.
// Configuration: write cfg_index/cfg_data with cfg_we high, only while idle.
// Sequencing: the back end handles one pixel at a time and pops no new
// one until it is done with the last. A pixel that gives no result goes
// through the idle and calc states; a border result and a clamped sum
// result also pass the done state; a full window in mean mode runs the
// 25-step serial divider for the rounded mean between calc and done. The
// done state holds while the receiver stalls a result not yet taken.
// A four-entry queue lets the front end keep accepting while the back end
// works or the receiver stalls; in_stall rises when the queue fills.
// Reset: clear the raster position, the queue and the output register and
// load the default registers. Line and column sum memories are not
// cleared; each entry is written before it is read in a normal frame.
// Receiver stall: hold the result and its fields until taken.
`default_nettype none

module box_window_filter_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bwf_pkg::PIXEL_BITS-1:0]    pixel,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [bwf_pkg::COL_W-1:0]              center_x,
    output logic [bwf_pkg::ROW_W-1:0]              center_y,
    output logic                                   window_full,
    output logic [bwf_pkg::VAL_W-1:0]              value,
    input  wire logic                              cfg_we,
    input  wire logic [bwf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bwf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [bwf_pkg::RAD_W-1:0] radius_x_reg;
    logic [bwf_pkg::RAD_W-1:0] radius_y_reg;
    logic [bwf_pkg::DIM_W-1:0] image_width_reg;
    logic [bwf_pkg::DIM_W-1:0] image_height_reg;
    logic                      filter_mode_reg;
    logic [bwf_pkg::VAL_W-1:0] max_value_reg;

    logic          push, pop, q_full, q_empty;
    bwf_pkg::cmd_t push_cmd, pop_cmd;

    // configuration registers; writes to unused indexes drop silently
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_x_reg     <= bwf_pkg::RAD_W'(1);
            radius_y_reg     <= bwf_pkg::RAD_W'(1);
            image_width_reg  <= bwf_pkg::DIM_W'(1024);
            image_height_reg <= bwf_pkg::DIM_W'(1024);
            filter_mode_reg  <= bwf_pkg::MODE_MEAN;
            max_value_reg    <= bwf_pkg::VAL_W'(255);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bwf_pkg::REG_RADIUS_X:     radius_x_reg     <= cfg_data[bwf_pkg::RAD_W-1:0];
                bwf_pkg::REG_RADIUS_Y:     radius_y_reg     <= cfg_data[bwf_pkg::RAD_W-1:0];
                bwf_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[bwf_pkg::DIM_W-1:0];
                bwf_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[bwf_pkg::DIM_W-1:0];
                bwf_pkg::REG_FILTER_MODE:  filter_mode_reg  <= cfg_data[0];
                bwf_pkg::REG_MAX_VALUE:    max_value_reg    <= cfg_data[bwf_pkg::VAL_W-1:0];
                default:                   ;
            endcase
        end
    end

    // accept, track position, build the row sum
    bwf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .q_full       (q_full),
        .radius_x     (radius_x_reg),
        .radius_y     (radius_y_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .push         (push),
        .cmd          (push_cmd)
    );

    // decouple front from back
    bwf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    // vertical sums, mean or clamp, result register
    bwf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (pop_cmd),
        .pop         (pop),
        .filter_mode (filter_mode_reg),
        .max_value   (max_value_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .center_x    (center_x),
        .center_y    (center_y),
        .window_full (window_full),
        .value       (value)
    );

endmodule

`default_nettype wire

// ===== sim/tb_box_window_filter_top.sv =====
// Self-checking testbench for the streaming box window filter top level.
`default_nettype none

module tb_box_window_filter_top;

    localparam int TIMEOUT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int TARGET_PIXELS  = 2000;

    typedef struct {
        logic [bwf_pkg::COL_W-1:0] cx;
        logic [bwf_pkg::ROW_W-1:0] cy;
        logic                      full;
        logic [bwf_pkg::VAL_W-1:0] val;
    } window_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [bwf_pkg::PIXEL_BITS-1:0] pixel;
    logic                           out_valid;
    logic                           out_stall;
    logic [bwf_pkg::COL_W-1:0]      center_x;
    logic [bwf_pkg::ROW_W-1:0]      center_y;
    logic                           window_full;
    logic [bwf_pkg::VAL_W-1:0]      value;
    logic                           cfg_we;
    logic [bwf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bwf_pkg::CFG_DATA_W-1:0] cfg_data;

    box_window_filter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .center_x    (center_x),
        .center_y    (center_y),
        .window_full (window_full),
        .value       (value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Free-running clock, period 10.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pixels waiting to be offered, and the window results predicted for
    // pixels already taken by the block.
    logic [bwf_pkg::PIXEL_BITS-1:0] pixel_fifo[$];
    window_result_t                 window_fifo[$];

    int  mismatches   = 0;
    int  pixels_sent  = 0;
    int  windows_seen = 0;
    int  full_seen    = 0;
    int  phases_run   = 0;
    int  cycle_count  = 0;
    bit  tx_no_gaps   = 1'b0;
    bit  rx_no_gaps   = 1'b0;
    bit  long_hold    = 1'b0;

    // Filter settings as the block sees them.
    logic [bwf_pkg::RAD_W-1:0]  cur_rx;
    logic [bwf_pkg::RAD_W-1:0]  cur_ry;
    logic [bwf_pkg::DIM_W-1:0]  cur_w;
    logic [bwf_pkg::DIM_W-1:0]  cur_h;
    logic                       cur_mode;
    logic [bwf_pkg::VAL_W-1:0]  cur_max;

    // Shadow copy of the block's raster position and running sums.
    int unsigned                    pos_x;
    int unsigned                    pos_y;
    logic [bwf_pkg::PIXEL_BITS-1:0] line_pixels[bwf_pkg::MAX_WINDOW];
    logic [bwf_pkg::RS_W-1:0]       hsum;
    logic [bwf_pkg::RS_W-1:0]       hsum_lines[bwf_pkg::MAX_WINDOW][bwf_pkg::MAX_WIDTH];
    logic [bwf_pkg::CS_W-1:0]       vsums[bwf_pkg::MAX_WIDTH];

    // Work out the window result, if any, completed by one accepted pixel.
    task automatic predict_window(input logic [bwf_pkg::PIXEL_BITS-1:0] px);
        int unsigned              rx, ry, wx, wy, w, h, cx, cy, n;
        logic [bwf_pkg::CS_W-1:0] vs;
        logic [bwf_pkg::CS_W-1:0] old;
        logic [bwf_pkg::CS_W:0]   mean;
        window_result_t           r;
        rx = (cur_rx > bwf_pkg::RADIUS_LIM) ? bwf_pkg::RADIUS_LIM : cur_rx;
        ry = (cur_ry > bwf_pkg::RADIUS_LIM) ? bwf_pkg::RADIUS_LIM : cur_ry;
        wx = 2 * rx + 1;
        wy = 2 * ry + 1;
        w  = cur_w;
        h  = cur_h;
        if (w == 0) w = 1;
        if (w > bwf_pkg::MAX_WIDTH) w = bwf_pkg::MAX_WIDTH;
        if (h == 0) h = 1;
        if (h > bwf_pkg::MAX_HEIGHT) h = bwf_pkg::MAX_HEIGHT;
        cx = pos_x % bwf_pkg::MAX_WIDTH;
        cy = pos_y;

        // Horizontal running sum, restarted at every row.
        if (cx == 0)
        begin
            foreach (line_pixels[i]) line_pixels[i] = '0;
            hsum = '0;
        end
        hsum = hsum + bwf_pkg::RS_W'(px) - bwf_pkg::RS_W'(line_pixels[wx-1]);
        for (int i = bwf_pkg::MAX_WINDOW - 1; i > 0; i--)
            line_pixels[i] = line_pixels[i-1];
        line_pixels[0] = px;

        // Vertical running sum per column.
        if (cy == 0)
            vs = bwf_pkg::CS_W'(hsum);
        else
        begin
            old = '0;
            if (cy >= wy)
                old = bwf_pkg::CS_W'(hsum_lines[(cy + bwf_pkg::MAX_WINDOW - wy)
                                                % bwf_pkg::MAX_WINDOW][cx]);
            vs = vsums[cx] + bwf_pkg::CS_W'(hsum) - old;
        end
        hsum_lines[cy % bwf_pkg::MAX_WINDOW][cx] = hsum;
        vsums[cx] = vs;

        if (cx >= rx && cy >= ry)
        begin
            r.cx   = bwf_pkg::COL_W'(cx - rx);
            r.cy   = bwf_pkg::ROW_W'(cy - ry);
            r.full = (cx >= 2 * rx) && (cy >= 2 * ry);
            r.val  = '0;
            if (r.full)
            begin
                if (cur_mode == bwf_pkg::MODE_MEAN)
                begin
                    n = wx * wy;
                    mean = ({1'b0, vs} + (bwf_pkg::CS_W + 1)'(n / 2))
                           / (bwf_pkg::CS_W + 1)'(n);
                    r.val = bwf_pkg::VAL_W'(mean);
                end
                else
                    r.val = (vs < bwf_pkg::CS_W'(cur_max)) ? bwf_pkg::VAL_W'(vs) : cur_max;
            end
            window_fifo.push_back(r);
        end

        // Advance the raster position.
        cx++;
        if (cx >= w)
        begin
            cx = 0;
            cy++;
            if (cy >= h) cy = 0;
        end
        pos_x = cx & 10'h3FF;
        pos_y = cy & 10'h3FF;
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch in %s for window (%0d,%0d): got %0d, expected %0d",
                 what, center_x, center_y, got, want);
        mismatches++;
    endtask

    // Sender: offer queued pixels, with a random gap after each one.
    int tx_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel    <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_window(pixel);
                pixels_sent++;
            end
            // Hold a stalled pixel; otherwise load the next one after its gap.
            if (!in_valid || !in_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pixel_fifo.size() > 0)
                begin
                    pixel    <= pixel_fifo.pop_front();
                    in_valid <= 1'b1;
                    tx_gap   <= tx_no_gaps ? 0 : $urandom_range(0, 17);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result transaction, then stall a random while.
    int rx_wait;
    always @(posedge clk or negedge rst_n)
    begin
        int             nxt;
        window_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait   <= 0;
        end
        else
        begin
            nxt = (rx_wait > 0) ? rx_wait - 1 : 0;
            if (out_valid && !out_stall)
            begin
                windows_seen++;
                if (window_fifo.size() == 0)
                    report("unexpected result", 1, 0);
                else
                begin
                    want = window_fifo.pop_front();
                    if (window_full) full_seen++;
                    if (center_x !== want.cx) report("center_x", center_x, want.cx);
                    if (center_y !== want.cy) report("center_y", center_y, want.cy);
                    if (window_full !== want.full)
                        report("window_full", window_full, want.full);
                    if (value !== want.val) report("value", value, want.val);
                end
                nxt = rx_no_gaps ? 0 : $urandom_range(0, 17);
            end
            rx_wait   <= nxt;
            out_stall <= (nxt > 0) || long_hold;
        end
    end

    // Hold off the receiver once for a long stretch so the queue fills up
    // and the input side stalls while the sender keeps offering pixels.
    initial
    begin
        wait (windows_seen >= 40);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("timeout with %0d results outstanding", window_fifo.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [bwf_pkg::CFG_IDX_W-1:0] idx, input int data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= bwf_pkg::CFG_DATA_W'(data);
    endtask

    // Wait until every pixel is in and every result is out, then let the
    // back end settle on pixels that yield no result.
    task automatic wait_idle();
        while (pixel_fifo.size() > 0 || in_valid || window_fifo.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Load a full setting while the block is idle.
    task automatic configure(input int rx, input int ry, input int w, input int h,
                             input int mode, input int maxv);
        wait_idle();
        write_reg(bwf_pkg::REG_RADIUS_X, rx);
        write_reg(bwf_pkg::REG_RADIUS_Y, ry);
        write_reg(bwf_pkg::REG_IMAGE_WIDTH, w);
        write_reg(bwf_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(bwf_pkg::REG_FILTER_MODE, mode);
        write_reg(bwf_pkg::REG_MAX_VALUE, maxv);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_rx   = bwf_pkg::RAD_W'(rx);
        cur_ry   = bwf_pkg::RAD_W'(ry);
        cur_w    = bwf_pkg::DIM_W'(w);
        cur_h    = bwf_pkg::DIM_W'(h);
        cur_mode = mode[0];
        cur_max  = bwf_pkg::VAL_W'(maxv);
        tx_no_gaps = ($urandom_range(0, 3) == 0);
        rx_no_gaps = ($urandom_range(0, 3) == 0);
        phases_run++;
    endtask

    function automatic logic [bwf_pkg::PIXEL_BITS-1:0] draw_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return bwf_pkg::PIXEL_BITS'($urandom);
        endcase
    endfunction

    // Queue whole frames so each phase ends back at the frame origin.
    task automatic queue_frames(input int w, input int h, input int frames);
        repeat (frames * w * h) pixel_fifo.push_back(draw_pixel());
    endtask

    initial
    begin
        int w, h, frames, left;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cur_rx = 1; cur_ry = 1; cur_w = 1024; cur_h = 1024;
        cur_mode = bwf_pkg::MODE_MEAN; cur_max = 255;
        pos_x = 0; pos_y = 0; hsum = '0;
        foreach (line_pixels[i]) line_pixels[i] = '0;
        repeat (8) @(posedge clk);
        rst_n = 1'b1;

        // Directed: 5x4 mean, full-scale and zero pixels to hit the
        // rounding extremes, top/left border and partial windows.
        configure(1, 1, 5, 4, bwf_pkg::MODE_MEAN, 255);
        repeat (10) pixel_fifo.push_back('1);
        repeat (5) pixel_fifo.push_back('0);
        repeat (5) pixel_fifo.push_back(16'hA5A5);

        // Window larger than a 1x1 image: no pixel yields a result.
        configure(7, 7, 1, 1, bwf_pkg::MODE_CLAMP, 65535);
        queue_frames(1, 1, 3);

        // Largest window, clamped sum with a zero ceiling, then a single-pixel window with full ceiling.
        configure(7, 7, 15, 15, bwf_pkg::MODE_CLAMP, 0);
        queue_frames(15, 15, 1);
        configure(0, 0, 3, 2, bwf_pkg::MODE_CLAMP, 65535);
        queue_frames(3, 2, 1);

        // Widest row, then a tall single column.
        configure(2, 0, 1024, 1, bwf_pkg::MODE_MEAN, 100);
        queue_frames(1024, 1, 1);
        configure(0, 3, 1, 200, bwf_pkg::MODE_CLAMP, 300);
        queue_frames(1, 200, 1);

        // Random phases of small images until enough pixels have gone in.
        while (pixels_sent + pixel_fifo.size() < TARGET_PIXELS)
        begin
            left   = TARGET_PIXELS - (pixels_sent + pixel_fifo.size());
            w      = $urandom_range(1, 40);
            h      = $urandom_range(1, 24);
            frames = $urandom_range(1, 2);
            if (w * h * frames > left)
            begin
                frames = 1;
                h      = (left + w - 1) / w;
                if (h > 24) h = 24;
            end
            configure($urandom_range(0, 7), $urandom_range(0, 7), w, h,
                      $urandom_range(0, 1),
                      ($urandom_range(0, 3) == 0) ? 0 :
                      ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(0, 65535));
            queue_frames(w, h, frames);
        end

        wait_idle();
        $display("ran %0d settings, %0d pixels in, %0d results out (%0d full windows)",
                 phases_run, pixels_sent, windows_seen, full_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
